>>> rtl/core/mipsdec_pkg.sv
// ----------------------------------------------------------------------------
// mipsdec_pkg
// Types, opcode/function codes and class lookup for the MIPS-I decoder.
// ----------------------------------------------------------------------------
package mipsdec_pkg;

    typedef enum logic [5:0] {
        MN_ADD     = 6'd0,  MN_ADDU    = 6'd1,  MN_AND     = 6'd2,  MN_NOR     = 6'd3,
        MN_OR      = 6'd4,  MN_SLT     = 6'd5,  MN_SLTU    = 6'd6,  MN_SUB     = 6'd7,
        MN_SUBU    = 6'd8,  MN_XOR     = 6'd9,  MN_SYSCALL = 6'd10, MN_DIV     = 6'd11,
        MN_DIVU    = 6'd12, MN_MULT    = 6'd13, MN_MULTU   = 6'd14, MN_SLL     = 6'd15,
        MN_SRA     = 6'd16, MN_SRL     = 6'd17, MN_SLLV    = 6'd18, MN_SRLV    = 6'd19,
        MN_SRAV    = 6'd20, MN_MFHI    = 6'd21, MN_MFLO    = 6'd22, MN_JR      = 6'd23,
        MN_JALR    = 6'd24, MN_MTHI    = 6'd25, MN_MTLO    = 6'd26, MN_ADDI    = 6'd27,
        MN_ADDIU   = 6'd28, MN_ANDI    = 6'd29, MN_BEQ     = 6'd30, MN_BNE     = 6'd31,
        MN_LB      = 6'd32, MN_LBU     = 6'd33, MN_LH      = 6'd34, MN_LHU     = 6'd35,
        MN_LUI     = 6'd36, MN_LW      = 6'd37, MN_ORI     = 6'd38, MN_SB      = 6'd39,
        MN_SLTI    = 6'd40, MN_SLTIU   = 6'd41, MN_SH      = 6'd42, MN_SW      = 6'd43,
        MN_XORI    = 6'd44, MN_J       = 6'd45, MN_JAL     = 6'd46, MN_UNKNOWN = 6'd47
    } t_mnemonic;

    typedef enum logic [3:0] {
        FORM_NONE      = 4'd0,
        FORM_RD_RS_RT  = 4'd1,
        FORM_RS_RT     = 4'd2,
        FORM_RD_RT_SA  = 4'd3,
        FORM_RD_RT_RS  = 4'd4,
        FORM_RD        = 4'd5,
        FORM_RS        = 4'd6,
        FORM_RD_RS     = 4'd7,
        FORM_RT_RS_IMM = 4'd8,
        FORM_RS_RT_IMM = 4'd9,
        FORM_RT_IMM    = 4'd10,
        FORM_MEM       = 4'd11,
        FORM_TARGET    = 4'd12,
        FORM_UNKNOWN   = 4'd13
    } t_form;

    typedef struct packed {
        t_mnemonic mn;
        t_form     form;
    } t_class;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    // function codes under OP_SPECIAL
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLTU    = 6'd41;
    localparam logic [5:0] FN_SLT     = 6'd42;

    function automatic t_class special_class(input logic [5:0] funct);
        t_class c;
        unique case (funct)
            FN_SLL:     c = '{MN_SLL,     FORM_RD_RT_SA};
            FN_SRL:     c = '{MN_SRL,     FORM_RD_RT_SA};
            FN_SRA:     c = '{MN_SRA,     FORM_RD_RT_SA};
            FN_SLLV:    c = '{MN_SLLV,    FORM_RD_RT_RS};
            FN_SRLV:    c = '{MN_SRLV,    FORM_RD_RT_RS};
            FN_SRAV:    c = '{MN_SRAV,    FORM_RD_RT_RS};
            FN_JR:      c = '{MN_JR,      FORM_RS};
            FN_JALR:    c = '{MN_JALR,    FORM_RD_RS};
            FN_SYSCALL: c = '{MN_SYSCALL, FORM_NONE};
            FN_MFHI:    c = '{MN_MFHI,    FORM_RD};
            FN_MTHI:    c = '{MN_MTHI,    FORM_RS};
            FN_MFLO:    c = '{MN_MFLO,    FORM_RD};
            FN_MTLO:    c = '{MN_MTLO,    FORM_RS};
            FN_MULT:    c = '{MN_MULT,    FORM_RS_RT};
            FN_MULTU:   c = '{MN_MULTU,   FORM_RS_RT};
            FN_DIV:     c = '{MN_DIV,     FORM_RS_RT};
            FN_DIVU:    c = '{MN_DIVU,    FORM_RS_RT};
            FN_ADD:     c = '{MN_ADD,     FORM_RD_RS_RT};
            FN_ADDU:    c = '{MN_ADDU,    FORM_RD_RS_RT};
            FN_SUB:     c = '{MN_SUB,     FORM_RD_RS_RT};
            FN_SUBU:    c = '{MN_SUBU,    FORM_RD_RS_RT};
            FN_AND:     c = '{MN_AND,     FORM_RD_RS_RT};
            FN_OR:      c = '{MN_OR,      FORM_RD_RS_RT};
            FN_XOR:     c = '{MN_XOR,     FORM_RD_RS_RT};
            FN_NOR:     c = '{MN_NOR,     FORM_RD_RS_RT};
            FN_SLTU:    c = '{MN_SLTU,    FORM_RD_RS_RT};
            FN_SLT:     c = '{MN_SLT,     FORM_RD_RS_RT};
            default:    c = '{MN_UNKNOWN, FORM_UNKNOWN};
        endcase
        return c;
    endfunction

    function automatic t_class primary_class(input logic [5:0] opcode);
        t_class c;
        unique case (opcode)
            OP_J:     c = '{MN_J,       FORM_TARGET};
            OP_JAL:   c = '{MN_JAL,     FORM_TARGET};
            OP_BEQ:   c = '{MN_BEQ,     FORM_RS_RT_IMM};
            OP_BNE:   c = '{MN_BNE,     FORM_RS_RT_IMM};
            OP_ADDI:  c = '{MN_ADDI,    FORM_RT_RS_IMM};
            OP_ADDIU: c = '{MN_ADDIU,   FORM_RT_RS_IMM};
            OP_SLTI:  c = '{MN_SLTI,    FORM_RT_RS_IMM};
            OP_SLTIU: c = '{MN_SLTIU,   FORM_RT_RS_IMM};
            OP_ANDI:  c = '{MN_ANDI,    FORM_RT_RS_IMM};
            OP_ORI:   c = '{MN_ORI,     FORM_RT_RS_IMM};
            OP_XORI:  c = '{MN_XORI,    FORM_RT_RS_IMM};
            OP_LUI:   c = '{MN_LUI,     FORM_RT_IMM};
            OP_LB:    c = '{MN_LB,      FORM_MEM};
            OP_LH:    c = '{MN_LH,      FORM_MEM};
            OP_LW:    c = '{MN_LW,      FORM_MEM};
            OP_LBU:   c = '{MN_LBU,     FORM_MEM};
            OP_LHU:   c = '{MN_LHU,     FORM_MEM};
            OP_SB:    c = '{MN_SB,      FORM_MEM};
            OP_SH:    c = '{MN_SH,      FORM_MEM};
            OP_SW:    c = '{MN_SW,      FORM_MEM};
            default:  c = '{MN_UNKNOWN, FORM_UNKNOWN};
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/mips_instruction_decoder.sv
// ----------------------------------------------------------------------------
// mips_instruction_decoder
// Byte-swaps a little-endian instruction word and decodes it into mnemonic,
// operand form, registers in printed order and immediate.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+----------------------------------
//   input   | i_in_valid  | o_in_stall   | i_raw_word
//   output  | o_out_valid | i_out_stall  | o_instr_word .. o_immediate
//
// Two register stages: input register, decode logic, result register.
// One transaction per cycle is sustained while the output is not stalled.
// A stalled result holds in the result register; the input side stalls only
// when both stages are full and the output is stalled.
// Synchronous active-low reset clears both valid flags.
// ----------------------------------------------------------------------------
module mips_instruction_decoder
    import mipsdec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_raw_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_instr_word,
    output logic [5:0]         o_mnemonic,
    output logic [3:0]         o_operand_form,
    output logic [4:0]         o_reg_first,
    output logic [4:0]         o_reg_second,
    output logic [4:0]         o_reg_third,
    output logic signed [25:0] o_immediate
);

    logic        r_in_vld;
    logic [31:0] r_raw;
    logic        r_out_vld;
    logic [31:0] r_instr;
    t_mnemonic   r_mn;
    t_form       r_form;
    logic [4:0]  r_reg1, r_reg2, r_reg3;
    logic [25:0] r_imm;

    logic        out_ready;
    logic        s1_ready;

    logic [31:0] w;
    logic [4:0]  rs, rt, rd, sa;
    logic [25:0] simm;
    t_class      cls;
    logic [4:0]  n_reg1, n_reg2, n_reg3;
    logic [25:0] n_imm;

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign s1_ready   = !r_in_vld || out_ready;
    assign o_in_stall = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s1_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_raw <= i_raw_word;
        end
    end

    // decode
    assign w    = {r_raw[7:0], r_raw[15:8], r_raw[23:16], r_raw[31:24]};
    assign rs   = w[25:21];
    assign rt   = w[20:16];
    assign rd   = w[15:11];
    assign sa   = w[10:6];
    assign simm = {{10{w[15]}}, w[15:0]};
    assign cls  = (w[31:26] == OP_SPECIAL) ? special_class(w[5:0])
                                           : primary_class(w[31:26]);

    always_comb begin
        n_reg1 = '0;
        n_reg2 = '0;
        n_reg3 = '0;
        n_imm  = '0;
        unique case (cls.form)
            FORM_RD_RS_RT: begin
                n_reg1 = rd; n_reg2 = rs; n_reg3 = rt;
            end
            FORM_RS_RT: begin
                n_reg1 = rs; n_reg2 = rt;
            end
            FORM_RD_RT_SA: begin
                n_reg1 = rd; n_reg2 = rt; n_imm = {21'd0, sa};
            end
            FORM_RD_RT_RS: begin
                n_reg1 = rd; n_reg2 = rt; n_reg3 = rs;
            end
            FORM_RD: begin
                n_reg1 = rd;
            end
            FORM_RS: begin
                n_reg1 = rs;
            end
            FORM_RD_RS: begin
                n_reg1 = rd; n_reg2 = rs;
            end
            FORM_RT_RS_IMM, FORM_MEM: begin
                n_reg1 = rt; n_reg2 = rs; n_imm = simm;
            end
            FORM_RS_RT_IMM: begin
                n_reg1 = rs; n_reg2 = rt; n_imm = simm;
            end
            FORM_RT_IMM: begin
                n_reg1 = rt; n_imm = simm;
            end
            FORM_TARGET: begin
                n_imm = w[25:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_vld) begin
            r_instr <= w;
            r_mn    <= cls.mn;
            r_form  <= cls.form;
            r_reg1  <= n_reg1;
            r_reg2  <= n_reg2;
            r_reg3  <= n_reg3;
            r_imm   <= n_imm;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_instr_word   = r_instr;
    assign o_mnemonic     = r_mn;
    assign o_operand_form = r_form;
    assign o_reg_first    = r_reg1;
    assign o_reg_second   = r_reg2;
    assign o_reg_third    = r_reg3;
    assign o_immediate    = $signed(r_imm);

endmodule
